// File: hw/rtl/srw_pkg.sv
// ----------------------------------------------------------------------------
// srw_pkg: shared types and constants of the soft range weight core
// Fixed-point formats, the two-pi constant with its reciprocal, register
// indexes and the item structs passed between the pipeline sections.
// ----------------------------------------------------------------------------
package srw_pkg;

    localparam int FRAC_BITS   = 12;
    localparam int WEIGHT_BITS = 16;

    localparam int SAMPLE_W  = 32;
    localparam int FALL_W    = 31;
    localparam int WIDE_W    = SAMPLE_W + 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int OUT_W       = WEIGHT_BITS + 1;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // Two pi in Q.FRAC_BITS, rounded from a Q60 value of pi
    localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0] TAU_Q  =
        (PI_Q60 + (64'd1 << (58 - FRAC_BITS))) >> (59 - FRAC_BITS);
    localparam int TAU_W = $clog2(TAU_Q);
    localparam int RES_W = TAU_W + 2;

    localparam logic signed [63:0]       TAU_S    = TAU_Q;
    localparam logic signed [RES_W-1:0]  TAU_RES  = TAU_Q[RES_W-1:0];
    localparam logic signed [RES_W-1:0]  TAU2_RES = TAU_RES <<< 1;
    localparam logic signed [WIDE_W-1:0] TAU_WIDE = TAU_Q[WIDE_W-1:0];

    // Reciprocal of two pi scaled so that it lands in [2^30, 2^31)
    localparam int RECIP_SHIFT = 30 + TAU_W;
    localparam logic [63:0] RECIP_FULL = (64'd1 << RECIP_SHIFT) / TAU_Q;
    localparam logic signed [SAMPLE_W-1:0] RECIP_M = RECIP_FULL[SAMPLE_W-1:0];

    localparam logic [OUT_W-1:0]       ONE_W     = {1'b1, {WEIGHT_BITS{1'b0}}};
    localparam logic [WEIGHT_BITS+1:0] THREE_ONE = {2'b11, {WEIGHT_BITS{1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BAND_LOW   = 3'd0,
        CFG_BAND_HIGH  = 3'd1,
        CFG_FALL_BELOW = 3'd2,
        CFG_FALL_ABOVE = 3'd3,
        CFG_ANGULAR    = 3'd4,
        CFG_INVERT     = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        BAND_ZERO,
        BAND_FULL,
        BAND_LOWER,
        BAND_UPPER
    } band_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] band_low;
        logic signed [SAMPLE_W-1:0] band_high;
        logic [FALL_W-1:0]          fall_below;
        logic [FALL_W-1:0]          fall_above;
        logic                       angular_mode;
        logic                       invert_weight;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] v;
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
        logic                       present;
    } sample_set_t;

    typedef struct packed {
        band_t             band;
        logic [FALL_W-1:0] num;
        logic [FALL_W-1:0] den;
    } frac_item_t;

    typedef struct packed {
        band_t                  band;
        logic [WEIGHT_BITS-1:0] t;
    } tpos_item_t;

endpackage

// File: hw/rtl/soft_range_weight_core.sv
// ----------------------------------------------------------------------------
// soft_range_weight_core: smoothstep band membership weight
// Stream core returning one Q1.16 weight for each Q19.12 sample.
// ----------------------------------------------------------------------------
// The core takes one sample per clock unless the output stalls, and returns
// one weight per sample, in order. Each item goes through the modulo two pi,
// band classification, bit-per-stage falloff divider and smoothstep and
// output sections, the divider being the longest. Every stage is pipelined,
// so throughput is one item per clock unless the output stalls. While an
// output item waits with m_tready low the whole pipeline holds, and one more
// input item is taken into an input skid register. Configuration writes are
// always taken (cfg_ready is high) and must be made only while no item is in
// flight.
// ----------------------------------------------------------------------------
module soft_range_weight_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [srw_pkg::SAMPLE_W-1:0]      s_tdata,   // [31:0] sample_value
    input  logic                              s_tuser,   // [0] value_present
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [srw_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [16:0] weight, rest zero
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [srw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [srw_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import srw_pkg::*;

    cfg_t                  cfg_next, cfg_reg;
    logic                  pipe_en;
    logic                  skid_valid_next, skid_valid_reg;
    logic [SAMPLE_W-1:0]   skid_sample_reg;
    logic                  skid_present_reg;
    logic                  feed_valid;
    sample_set_t           feed_item;
    logic                  wrap_valid;
    sample_set_t           wrap_item;
    logic                  cls_valid;
    frac_item_t            cls_item;
    logic                  div_valid;
    tpos_item_t            div_item;
    logic                  out_valid;
    logic [OUT_W-1:0]      out_weight;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                CFG_BAND_LOW:   cfg_next.band_low      = $signed(cfg_data[SAMPLE_W-1:0]);
                CFG_BAND_HIGH:  cfg_next.band_high     = $signed(cfg_data[SAMPLE_W-1:0]);
                CFG_FALL_BELOW: cfg_next.fall_below    = cfg_data[FALL_W-1:0];
                CFG_FALL_ABOVE: cfg_next.fall_above    = cfg_data[FALL_W-1:0];
                CFG_ANGULAR:    cfg_next.angular_mode  = cfg_data[0];
                CFG_INVERT:     cfg_next.invert_weight = cfg_data[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // advance everything together unless the output item is waiting
    assign pipe_en  = !out_valid || m_tready;
    assign s_tready = !skid_valid_reg;

    assign feed_valid        = skid_valid_reg || s_tvalid;
    assign feed_item.v       = $signed(skid_valid_reg ? skid_sample_reg : s_tdata);
    assign feed_item.lo      = cfg_reg.band_low;
    assign feed_item.hi      = cfg_reg.band_high;
    assign feed_item.present = skid_valid_reg ? skid_present_reg : s_tuser;

    always_comb begin
        skid_valid_next = skid_valid_reg;
        if (pipe_en) begin
            skid_valid_next = 1'b0;
        end else if (s_tvalid && s_tready) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    // catch an item that arrives while the pipeline holds
    always_ff @(posedge aclk) begin
        if (!pipe_en && s_tvalid && s_tready) begin
            skid_sample_reg  <= s_tdata;
            skid_present_reg <= s_tuser;
        end
    end

    srw_wrap u_wrap (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pipe_en   (pipe_en),
        .cfg       (cfg_reg),
        .in_valid  (feed_valid && pipe_en),
        .in_item   (feed_item),
        .out_valid (wrap_valid),
        .out_item  (wrap_item)
    );

    srw_classify u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pipe_en   (pipe_en),
        .cfg       (cfg_reg),
        .in_valid  (wrap_valid),
        .in_item   (wrap_item),
        .out_valid (cls_valid),
        .out_item  (cls_item)
    );

    srw_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pipe_en   (pipe_en),
        .in_valid  (cls_valid),
        .in_item   (cls_item),
        .out_valid (div_valid),
        .out_item  (div_item)
    );

    srw_smooth u_smooth (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pipe_en    (pipe_en),
        .cfg        (cfg_reg),
        .in_valid   (div_valid),
        .in_item    (div_item),
        .out_valid  (out_valid),
        .out_weight (out_weight)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = OUT_TDATA_W'(out_weight);

`ifndef SYNTH
    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> !$past(pipe_en))
        else $error("skid register filled while the pipeline advanced");
`endif

endmodule

// File: hw/rtl/srw_wrap.sv
// ----------------------------------------------------------------------------
// srw_wrap: modulo two pi for sample and band edges (angular mode only)
// Three lanes in lockstep. Quotient by reciprocal multiply, remainder by a
// constant multiply and subtract, then one add or subtract of two pi fixes it.
// ----------------------------------------------------------------------------
module srw_wrap (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pipe_en,
    input  srw_pkg::cfg_t       cfg,
    input  logic                in_valid,
    input  srw_pkg::sample_set_t in_item,
    output logic                out_valid,
    output srw_pkg::sample_set_t out_item
);
    import srw_pkg::*;

    localparam int LANES = 3;

    logic signed [SAMPLE_W-1:0]   lane_in   [LANES];
    logic signed [2*SAMPLE_W-1:0] prod_next [LANES];
    logic signed [2*SAMPLE_W-1:0] prod_reg  [LANES];
    logic signed [SAMPLE_W-1:0]   x1_reg    [LANES];
    logic signed [RES_W-1:0]      res_next  [LANES];
    logic signed [RES_W-1:0]      res_reg   [LANES];
    logic signed [SAMPLE_W-1:0]   x2_reg    [LANES];
    logic signed [SAMPLE_W-1:0]   out_next  [LANES];
    logic signed [SAMPLE_W-1:0]   out_reg   [LANES];
    logic [2:0]                   valid_reg;
    logic                         present1_reg;
    logic                         present2_reg;
    logic                         present3_reg;

    assign lane_in[0] = in_item.v;
    assign lane_in[1] = in_item.lo;
    assign lane_in[2] = in_item.hi;

    always_comb begin
        logic signed [SAMPLE_W-1:0] quot;
        logic signed [63:0]         diff_full;
        logic signed [RES_W-1:0]    fix;
        for (int l = 0; l < LANES; l++) begin
            prod_next[l] = lane_in[l] * RECIP_M;
            // estimate is exact or one off, so the residue lies in [-tau, 2*tau)
            quot         = SAMPLE_W'(prod_reg[l] >>> RECIP_SHIFT);
            diff_full    = 64'(x1_reg[l]) - 64'(quot) * TAU_S;
            res_next[l]  = RES_W'(diff_full);
            if (res_reg[l] < 0) begin
                fix = res_reg[l] + TAU_RES;
            end else if (res_reg[l] >= TAU_RES) begin
                fix = res_reg[l] - TAU_RES;
            end else begin
                fix = res_reg[l];
            end
            out_next[l] = cfg.angular_mode ? SAMPLE_W'(fix) : x2_reg[l];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (pipe_en) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int l = 0; l < LANES; l++) begin
                prod_reg[l] <= prod_next[l];
                x1_reg[l]   <= lane_in[l];
                res_reg[l]  <= res_next[l];
                x2_reg[l]   <= x1_reg[l];
                out_reg[l]  <= out_next[l];
            end
            present1_reg <= in_item.present;
            present2_reg <= present1_reg;
            present3_reg <= present2_reg;
        end
    end

    assign out_valid        = valid_reg[2];
    assign out_item.v       = out_reg[0];
    assign out_item.lo      = out_reg[1];
    assign out_item.hi      = out_reg[2];
    assign out_item.present = present3_reg;

`ifndef SYNTH
    a_residue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[1] |->
            (res_reg[0] >= -TAU_RES) && (res_reg[0] < TAU2_RES) &&
            (res_reg[1] >= -TAU_RES) && (res_reg[1] < TAU2_RES) &&
            (res_reg[2] >= -TAU_RES) && (res_reg[2] < TAU2_RES))
        else $error("wrap residue outside one correction step");
`endif

endmodule

// File: hw/rtl/srw_classify.sv
// ----------------------------------------------------------------------------
// srw_classify: band unrolling and falloff selection
// Unrolls a wrapped band, places the sample against the band and its
// falloff edges, and picks numerator and width for the falloff fraction.
// ----------------------------------------------------------------------------
module srw_classify (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 pipe_en,
    input  srw_pkg::cfg_t        cfg,
    input  logic                 in_valid,
    input  srw_pkg::sample_set_t in_item,
    output logic                 out_valid,
    output srw_pkg::frac_item_t  out_item
);
    import srw_pkg::*;

    logic signed [WIDE_W-1:0] fb_w;
    logic signed [WIDE_W-1:0] fa_w;
    logic signed [WIDE_W-1:0] v_next,  v_reg;
    logic signed [WIDE_W-1:0] lo_next, lo_reg;
    logic signed [WIDE_W-1:0] hi_next, hi_reg;
    logic signed [WIDE_W-1:0] low_edge_next,  low_edge_reg;
    logic signed [WIDE_W-1:0] high_edge_next, high_edge_reg;
    logic                     present_reg;
    logic [1:0]               valid_reg;
    frac_item_t               item_next, item_reg;

    assign fb_w = $signed({{(WIDE_W - FALL_W){1'b0}}, cfg.fall_below});
    assign fa_w = $signed({{(WIDE_W - FALL_W){1'b0}}, cfg.fall_above});

    // stage one: unroll a band that wraps past two pi
    always_comb begin
        logic wrap_band;
        wrap_band = cfg.angular_mode && (in_item.lo > in_item.hi);
        lo_next   = WIDE_W'(in_item.lo);
        v_next    = WIDE_W'(in_item.v);
        hi_next   = WIDE_W'(in_item.hi);
        if (wrap_band) begin
            hi_next = WIDE_W'(in_item.hi) + TAU_WIDE;
            if (in_item.v < in_item.lo) begin
                v_next = WIDE_W'(in_item.v) + TAU_WIDE;
            end
        end
        low_edge_next  = lo_next - fb_w;
        high_edge_next = hi_next + fa_w;
    end

    // stage two: classify and pick the fraction operands
    always_comb begin
        logic                     below;
        logic signed [WIDE_W-1:0] num_lo;
        logic signed [WIDE_W-1:0] num_hi;
        below  = v_reg < lo_reg;
        num_lo = v_reg - low_edge_reg;
        num_hi = v_reg - hi_reg;
        item_next.num = below ? num_lo[FALL_W-1:0] : num_hi[FALL_W-1:0];
        item_next.den = below ? cfg.fall_below : cfg.fall_above;
        if (!present_reg) begin
            item_next.band = BAND_ZERO;
        end else if (!below && v_reg <= hi_reg) begin
            item_next.band = BAND_FULL;
        end else if (below) begin
            if (cfg.fall_below == '0 || v_reg <= low_edge_reg) begin
                item_next.band = BAND_ZERO;
            end else begin
                item_next.band = BAND_LOWER;
            end
        end else if (cfg.fall_above == '0 || v_reg >= high_edge_reg) begin
            item_next.band = BAND_ZERO;
        end else begin
            item_next.band = BAND_UPPER;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (pipe_en) begin
            valid_reg <= {valid_reg[0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            v_reg         <= v_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            low_edge_reg  <= low_edge_next;
            high_edge_reg <= high_edge_next;
            present_reg   <= in_item.present;
            item_reg      <= item_next;
        end
    end

    assign out_valid = valid_reg[1];
    assign out_item  = item_reg;

endmodule

// File: hw/rtl/srw_div.sv
// ----------------------------------------------------------------------------
// srw_div: pipelined restoring divider for the falloff position
// One quotient bit per stage gives floor(num * 2^WEIGHT_BITS / den) for a
// numerator already below the width.
// ----------------------------------------------------------------------------
module srw_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pipe_en,
    input  logic                in_valid,
    input  srw_pkg::frac_item_t in_item,
    output logic                out_valid,
    output srw_pkg::tpos_item_t out_item
);
    import srw_pkg::*;

    localparam int STEPS = WEIGHT_BITS;

    logic [STEPS-1:0]       valid_reg;
    band_t                  band_reg  [STEPS];
    band_t                  band_next [STEPS];
    logic [FALL_W-1:0]      den_reg   [STEPS];
    logic [FALL_W-1:0]      den_next  [STEPS];
    logic [FALL_W-1:0]      rem_reg   [STEPS];
    logic [FALL_W-1:0]      rem_next  [STEPS];
    logic [WEIGHT_BITS-1:0] quot_reg  [STEPS];
    logic [WEIGHT_BITS-1:0] quot_next [STEPS];

    always_comb begin
        logic [FALL_W-1:0]      rem_src;
        logic [WEIGHT_BITS-1:0] quot_src;
        logic [FALL_W:0]        rem_dbl;
        logic                   ge;
        for (int k = 0; k < STEPS; k++) begin
            if (k == 0) begin
                rem_src      = in_item.num;
                quot_src     = '0;
                den_next[k]  = in_item.den;
                band_next[k] = in_item.band;
            end else begin
                rem_src      = rem_reg[k-1];
                quot_src     = quot_reg[k-1];
                den_next[k]  = den_reg[k-1];
                band_next[k] = band_reg[k-1];
            end
            rem_dbl      = {rem_src, 1'b0};
            ge           = rem_dbl >= {1'b0, den_next[k]};
            rem_next[k]  = ge ? FALL_W'(rem_dbl - {1'b0, den_next[k]})
                              : FALL_W'(rem_dbl);
            quot_next[k] = {quot_src[WEIGHT_BITS-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (pipe_en) begin
            valid_reg <= {valid_reg[STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int k = 0; k < STEPS; k++) begin
                band_reg[k] <= band_next[k];
                den_reg[k]  <= den_next[k];
                rem_reg[k]  <= rem_next[k];
                quot_reg[k] <= quot_next[k];
            end
        end
    end

    assign out_valid     = valid_reg[STEPS-1];
    assign out_item.band = band_reg[STEPS-1];
    assign out_item.t    = quot_reg[STEPS-1];

`ifndef SYNTH
    a_num_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && (in_item.band == BAND_LOWER || in_item.band == BAND_UPPER)
            |-> (in_item.num != '0) && (in_item.num < in_item.den))
        else $error("falloff numerator not inside the falloff width");
    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[STEPS-1] &&
            (band_reg[STEPS-1] == BAND_LOWER || band_reg[STEPS-1] == BAND_UPPER)
            |-> rem_reg[STEPS-1] < den_reg[STEPS-1])
        else $error("divider remainder not below divisor");
`endif

endmodule

// File: hw/rtl/srw_smooth.sv
// ----------------------------------------------------------------------------
// srw_smooth: smoothstep and output weight
// Squares the position, scales by (3 - 2t), then forms the band weight,
// applies the invert option and holds the result for the output channel.
// ----------------------------------------------------------------------------
module srw_smooth (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        pipe_en,
    input  srw_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    input  srw_pkg::tpos_item_t         in_item,
    output logic                        out_valid,
    output logic [srw_pkg::OUT_W-1:0]   out_weight
);
    import srw_pkg::*;

    localparam int W = WEIGHT_BITS;

    logic [2:0]         valid_reg;
    logic [2*W-1:0]     sq_next, sq_reg;
    logic [W-1:0]       t1_reg;
    band_t              band1_reg, band2_reg;
    logic [W+1:0]       slope;
    logic [2*W+1:0]     prod_next, prod_reg;
    logic [OUT_W-1:0]   s_w;
    logic [OUT_W-1:0]   base;
    logic [OUT_W-1:0]   weight_next, weight_reg;

    assign sq_next   = in_item.t * in_item.t;
    assign slope     = THREE_ONE - {1'b0, t1_reg, 1'b0};
    assign prod_next = sq_reg[2*W-1:W] * slope;
    assign s_w       = prod_reg[2*W:W];

    always_comb begin
        case (band2_reg)
            BAND_ZERO:  base = '0;
            BAND_FULL:  base = ONE_W;
            BAND_LOWER: base = s_w;
            BAND_UPPER: base = ONE_W - s_w;
            default:    base = '0;
        endcase
        weight_next = cfg.invert_weight ? ONE_W - base : base;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (pipe_en) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sq_reg     <= sq_next;
            t1_reg     <= in_item.t;
            band1_reg  <= in_item.band;
            prod_reg   <= prod_next;
            band2_reg  <= band1_reg;
            weight_reg <= weight_next;
        end
    end

    assign out_valid  = valid_reg[2];
    assign out_weight = weight_reg;

`ifndef SYNTH
    a_weight_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[1] |-> (s_w <= ONE_W) && (weight_next <= ONE_W))
        else $error("weight above one");
`endif

endmodule
